[src/ofdm_null_symbol_detector_assert.svh]
// Assertion macros shared by the null-symbol detector checkers.
`ifndef OFDM_NULL_SYMBOL_DETECTOR_ASSERT_SVH
`define OFDM_NULL_SYMBOL_DETECTOR_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define ONSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define ONSD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[src/onsd_pkg.sv]
// Shared types and constants of the OFDM null-symbol detector.
`timescale 1ns / 1ps

package onsd_pkg;

  localparam int WINDOW_LENGTH  = 50;
  localparam int LEVEL_SHIFT    = 17;
  localparam int WARMUP_SYMBOLS = 10;
  localparam int MAG_BITS       = 16;
  localparam int PERCENT_SCALE  = 100;

  localparam int SL_W    = 12;
  localparam int PCT_W   = 7;
  localparam int CFG_W   = 12;
  localparam int LEVEL_W = 16;
  localparam int SI_W    = 16;

  localparam int PTR_W    = $clog2(WINDOW_LENGTH);
  localparam int CNT_W    = SL_W + $clog2(WARMUP_SYMBOLS + 1);
  localparam int SCALE_W  = $clog2(PERCENT_SCALE);
  localparam int MAGS_W   = MAG_BITS + SCALE_W;
  localparam int SUMS_W   = MAGS_W + $clog2(WINDOW_LENGTH);
  localparam int ACC_W    = MAG_BITS + LEVEL_SHIFT;
  localparam int PCTW_W   = PCT_W + $clog2(WINDOW_LENGTH);
  localparam int LHS_W    = SUMS_W + LEVEL_SHIFT;
  localparam int RHS_W    = PCTW_W + ACC_W;
  localparam int CMP_W    = (LHS_W > RHS_W) ? LHS_W : RHS_W;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NULL_LENGTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIP_PERCENT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_PERCENT   = 2'd3;

  localparam logic [SL_W-1:0]  SYMBOL_LENGTH_RST = 12'd2552;
  localparam logic [SL_W-1:0]  NULL_LENGTH_RST   = 12'd2656;
  localparam logic [PCT_W-1:0] DIP_PERCENT_RST   = 7'd40;
  localparam logic [PCT_W-1:0] END_PERCENT_RST   = 7'd75;

  typedef enum logic [1:0] {
    PH_WARM = 2'd0,
    PH_FILL = 2'd1,
    PH_DIP  = 2'd2,
    PH_END  = 2'd3
  } phase_e;

  typedef struct packed {
    logic [SL_W-1:0] symbol_length;
    logic [SL_W-1:0] null_length;
  } cfg_t;

  typedef struct packed {
    logic   null_end;
    logic   search_timeout;
    phase_e phase;
  } res_t;

endpackage

[src/onsd_tracker.sv]
// Window sum, phase sequencer and threshold tests of the null-symbol detector.
`timescale 1ns / 1ps

module onsd_tracker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  step_i,
  input  onsd_pkg::cfg_t                        cfg_i,
  input  logic [onsd_pkg::MAGS_W-1:0]           mag_scaled_i,
  input  logic [onsd_pkg::CMP_W-1:0]            dip_prod_i,
  input  logic [onsd_pkg::CMP_W-1:0]            end_prod_i,
  output onsd_pkg::res_t                        res_o
);

  localparam int PTR_W  = onsd_pkg::PTR_W;
  localparam int CNT_W  = onsd_pkg::CNT_W;
  localparam int SI_W   = onsd_pkg::SI_W;
  localparam int SUMS_W = onsd_pkg::SUMS_W;
  localparam int MAGS_W = onsd_pkg::MAGS_W;
  localparam int CMP_W  = onsd_pkg::CMP_W;
  localparam int SL_W   = onsd_pkg::SL_W;

  onsd_pkg::phase_e    phase_q, phase_d;
  logic [PTR_W-1:0]    ptr_q, ptr_d;
  logic [SUMS_W-1:0]   sum_q, sum_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [SI_W-1:0]     si_q, si_d;

  logic [MAGS_W-1:0]   win_mem [onsd_pkg::WINDOW_LENGTH];
  logic [MAGS_W-1:0]   rd_q;
  logic                wr_en;

  logic [SUMS_W-1:0]   sum_new;
  logic [PTR_W-1:0]    ptr_inc;
  logic [CNT_W-1:0]    cnt_inc;
  logic [CNT_W-1:0]    warm_limit;
  logic [SI_W-1:0]     si_inc;
  logic [SL_W:0]       dip_limit;
  logic [SL_W+1:0]     end_limit;
  logic [SI_W:0]       end_index;
  logic [CMP_W-1:0]    lhs;
  logic                dip_hit, end_hit;
  logic                warm_done, fill_done, dip_timeout, end_timeout;
  logic                found_end, timed_out;

  // shared datapath and decisions
  always_comb begin
    if (phase_q == onsd_pkg::PH_FILL) begin
      sum_new = sum_q + SUMS_W'(mag_scaled_i);
    end else begin
      sum_new = sum_q + SUMS_W'(mag_scaled_i) - SUMS_W'(rd_q);
    end
    ptr_inc = (ptr_q == PTR_W'(onsd_pkg::WINDOW_LENGTH - 1)) ? '0 : ptr_q + PTR_W'(1);
    cnt_inc = cnt_q + CNT_W'(1);
    si_inc  = (si_q == '1) ? si_q : si_q + SI_W'(1);
    warm_limit = CNT_W'(cfg_i.symbol_length) * CNT_W'(onsd_pkg::WARMUP_SYMBOLS);
    dip_limit  = {cfg_i.symbol_length, 1'b0};
    end_limit  = (SL_W+2)'(dip_limit) + (SL_W+2)'(cfg_i.null_length);
    end_index  = (SI_W+1)'(si_inc) + (SI_W+1)'(onsd_pkg::WINDOW_LENGTH);
    lhs        = CMP_W'({sum_new, {onsd_pkg::LEVEL_SHIFT{1'b0}}});
    dip_hit    = (lhs <= dip_prod_i);
    end_hit    = (lhs >= end_prod_i);
    warm_done   = (cnt_inc >= warm_limit);
    fill_done   = (cnt_inc >= CNT_W'(onsd_pkg::WINDOW_LENGTH));
    dip_timeout = ((SI_W+1)'(si_inc) > (SI_W+1)'(dip_limit));
    end_timeout = (end_index > (SI_W+1)'(end_limit));
    found_end = 1'b0;
    timed_out = 1'b0;
    case (phase_q)
      onsd_pkg::PH_FILL: found_end = fill_done && dip_hit && end_hit;
      onsd_pkg::PH_DIP: begin
        timed_out = dip_timeout;
        found_end = !dip_timeout && dip_hit && end_hit;
      end
      onsd_pkg::PH_END: begin
        timed_out = end_timeout;
        found_end = !end_timeout && end_hit;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    ptr_d   = ptr_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    si_d    = si_q;
    if (step_i) begin
      case (phase_q)
        onsd_pkg::PH_WARM: begin
          cnt_d = cnt_inc;
          if (warm_done) begin
            phase_d = onsd_pkg::PH_FILL;
            cnt_d   = '0;
          end
        end
        onsd_pkg::PH_FILL: begin
          sum_d = sum_new;
          ptr_d = ptr_inc;
          cnt_d = cnt_inc;
          if (fill_done) begin
            cnt_d   = '0;
            si_d    = '0;
            phase_d = dip_hit ? onsd_pkg::PH_END : onsd_pkg::PH_DIP;
          end
        end
        onsd_pkg::PH_DIP: begin
          sum_d = sum_new;
          ptr_d = ptr_inc;
          si_d  = si_inc;
          if (!dip_timeout && dip_hit) begin
            phase_d = onsd_pkg::PH_END;
          end
        end
        default: begin
          sum_d = sum_new;
          ptr_d = ptr_inc;
          si_d  = si_inc;
        end
      endcase
      if (found_end || timed_out || (phase_q == onsd_pkg::PH_WARM && warm_done)) begin
        phase_d = onsd_pkg::PH_FILL;
        ptr_d   = '0;
        sum_d   = '0;
        cnt_d   = '0;
        si_d    = '0;
      end
    end
  end

  // outputs
  always_comb begin
    res_o.null_end       = found_end;
    res_o.search_timeout = timed_out;
    res_o.phase          = phase_d;
  end

  assign wr_en = step_i && (phase_q != onsd_pkg::PH_WARM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= onsd_pkg::PH_WARM;
      ptr_q   <= '0;
      sum_q   <= '0;
      cnt_q   <= '0;
      si_q    <= '0;
    end else begin
      phase_q <= phase_d;
      ptr_q   <= ptr_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      si_q    <= si_d;
    end
  end

  // window store; read is prefetched at the next pointer
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      win_mem[ptr_q] <= mag_scaled_i;
    end
    rd_q <= win_mem[ptr_d];
  end

endmodule

[src/ofdm_null_symbol_detector.sv]
// Top level of the OFDM null-symbol detector: handshake, level tracking, thresholds.
`timescale 1ns / 1ps
//
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_stall_o   magnitude_i
//  out      output     out_valid_o / out_stall_i null_end_o, search_timeout_o,
//                                                phase_code_o, level_o
//  cfg      input      cfg_we_i                  cfg_index_i, cfg_data_i
//
//  One transaction per clock while the output is not stalled.
//  The level accumulator updates on input, the product stage follows, and the
//  phase sequencer with its window store sets the result register.
//  Reset clears control state, the level and the window sum; the window store
//  is always filled before it is read.
//  A stalled output holds its result; bubbles still close up behind it.

module ofdm_null_symbol_detector (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [onsd_pkg::MAG_BITS-1:0]      magnitude_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               null_end_o,
  output logic                               search_timeout_o,
  output logic [1:0]                         phase_code_o,
  output logic [onsd_pkg::LEVEL_W-1:0]       level_o,
  input  logic                               cfg_we_i,
  input  logic [onsd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [onsd_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int ACC_W   = onsd_pkg::ACC_W;
  localparam int CMP_W   = onsd_pkg::CMP_W;
  localparam int MAGS_W  = onsd_pkg::MAGS_W;
  localparam int PCTW_W  = onsd_pkg::PCTW_W;
  localparam int PCT_W   = onsd_pkg::PCT_W;
  localparam int SL_W    = onsd_pkg::SL_W;
  localparam int LEVEL_W = onsd_pkg::LEVEL_W;

  logic [SL_W-1:0]   symbol_length_q;
  logic [SL_W-1:0]   null_length_q;
  logic [PCT_W-1:0]  dip_percent_q;
  logic [PCT_W-1:0]  end_percent_q;

  logic [ACC_W-1:0]  acc_q, acc_d;

  logic              v1_q, v2_q, v3_q;
  logic [onsd_pkg::MAG_BITS-1:0] mag1_q;
  logic [MAGS_W-1:0] mag2_q;
  logic [CMP_W-1:0]  dip_prod2_q, end_prod2_q;
  logic [LEVEL_W-1:0] level2_q, level3_q;
  onsd_pkg::res_t    res3_q;
  onsd_pkg::res_t    res;
  onsd_pkg::cfg_t    cfg;

  logic [PCTW_W-1:0] dip_scale, end_scale;
  logic              s1_free, s2_free, s3_free;
  logic              accept, mv2, mv3;

  assign s3_free = !v3_q || !out_stall_i;
  assign mv3     = v2_q && s3_free;
  assign s2_free = !v2_q || mv3;
  assign mv2     = v1_q && s2_free;
  assign s1_free = !v1_q || mv2;
  assign accept  = in_valid_i && s1_free;
  assign in_stall_o = !s1_free;

  assign acc_d = acc_q + ACC_W'(magnitude_i) - (acc_q >> onsd_pkg::LEVEL_SHIFT);

  assign dip_scale = PCTW_W'(dip_percent_q) * PCTW_W'(onsd_pkg::WINDOW_LENGTH);
  assign end_scale = PCTW_W'(end_percent_q) * PCTW_W'(onsd_pkg::WINDOW_LENGTH);

  assign cfg.symbol_length = symbol_length_q;
  assign cfg.null_length   = null_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      symbol_length_q <= onsd_pkg::SYMBOL_LENGTH_RST;
      null_length_q   <= onsd_pkg::NULL_LENGTH_RST;
      dip_percent_q   <= onsd_pkg::DIP_PERCENT_RST;
      end_percent_q   <= onsd_pkg::END_PERCENT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        onsd_pkg::CFG_SYMBOL_LENGTH: symbol_length_q <= cfg_data_i[SL_W-1:0];
        onsd_pkg::CFG_NULL_LENGTH:   null_length_q   <= cfg_data_i[SL_W-1:0];
        onsd_pkg::CFG_DIP_PERCENT:   dip_percent_q   <= cfg_data_i[PCT_W-1:0];
        onsd_pkg::CFG_END_PERCENT:   end_percent_q   <= cfg_data_i[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
    end else begin
      if (accept) begin
        acc_q <= acc_d;
      end
      if (s1_free) begin
        v1_q <= in_valid_i;
      end
      if (s2_free) begin
        v2_q <= v1_q;
      end
      if (s3_free) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mag1_q <= magnitude_i;
    end
    if (mv2) begin
      mag2_q      <= MAGS_W'(mag1_q) * MAGS_W'(onsd_pkg::PERCENT_SCALE);
      dip_prod2_q <= CMP_W'(dip_scale) * CMP_W'(acc_q);
      end_prod2_q <= CMP_W'(end_scale) * CMP_W'(acc_q);
      level2_q    <= LEVEL_W'(acc_q >> onsd_pkg::LEVEL_SHIFT);
    end
    if (mv3) begin
      res3_q   <= res;
      level3_q <= level2_q;
    end
  end

  onsd_tracker u_tracker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (mv3),
    .cfg_i        (cfg),
    .mag_scaled_i (mag2_q),
    .dip_prod_i   (dip_prod2_q),
    .end_prod_i   (end_prod2_q),
    .res_o        (res)
  );

  assign out_valid_o      = v3_q;
  assign null_end_o       = res3_q.null_end;
  assign search_timeout_o = res3_q.search_timeout;
  assign phase_code_o     = res3_q.phase;
  assign level_o          = level3_q;

endmodule

[src/onsd_checker.sv]
// Port-level checker for the OFDM null-symbol detector, bound to the top level.
`timescale 1ns / 1ps
`include "ofdm_null_symbol_detector_assert.svh"

module onsd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          null_end_o,
  input logic                          search_timeout_o,
  input logic [1:0]                    phase_code_o,
  input logic [onsd_pkg::LEVEL_W-1:0]  level_o
);

  `ONSD_ASSERT_NEVER(a_end_and_timeout, out_valid_o && null_end_o && search_timeout_o, "null end and timeout in one transaction")
  `ONSD_ASSERT(a_end_rearms, out_valid_o && null_end_o |-> phase_code_o == onsd_pkg::PH_FILL, "null end did not re-arm to window fill")
  `ONSD_ASSERT(a_timeout_fill, out_valid_o && search_timeout_o |-> phase_code_o == onsd_pkg::PH_FILL, "timeout did not return to window fill")
  `ONSD_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(level_o) && $stable(phase_code_o), "stalled result changed")

endmodule

bind ofdm_null_symbol_detector onsd_checker u_onsd_checker (.*);
